// ----- sv/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants for the text console writer
// Field widths, control codes, sequencer states and RAM control bundle.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int CHAR_W      = 8;
	localparam int COL_W       = 7;
	localparam int ROW_W       = 6;
	// row * columns + column fits in this many bits for any legal geometry
	localparam int ADDR_FULL_W = 14;

	localparam logic [CHAR_W-1:0] CODE_RETURN    = 8'd13;
	localparam logic [CHAR_W-1:0] CODE_LINEFEED  = 8'd10;
	localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'd8;

	localparam logic OP_PUT  = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef enum logic [1:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLEAR,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic              we;
		logic              re;
		logic [CHAR_W-1:0] wdata;
	} ram_ctl_t;

endpackage

// ----- sv/tcw_addr.sv -----
// ----------------------------------------------------------------------------
// tcw_addr: cell address generator
// Maps a logical row through the scroll base and forms row * COLUMNS + col.
// ----------------------------------------------------------------------------
module tcw_addr #(
	parameter int ROWS    = 60,
	parameter int COLUMNS = 80,
	parameter int ADDR_W  = 13
) (
	input  logic                      use_offset,
	input  logic [tcw_pkg::ROW_W-1:0] row,
	input  logic [tcw_pkg::COL_W-1:0] col,
	input  logic [tcw_pkg::ROW_W-1:0] base,
	output logic [ADDR_W-1:0]         addr
);

	localparam logic [tcw_pkg::ROW_W:0] ROWS_V = (tcw_pkg::ROW_W + 1)'(ROWS);

	logic [tcw_pkg::ROW_W:0]         row_sum;
	logic [tcw_pkg::ROW_W:0]         row_wrap;
	logic [tcw_pkg::ROW_W-1:0]       row_phys;
	logic [tcw_pkg::ADDR_FULL_W-1:0] addr_full;

	always_comb begin
		row_sum = {1'b0, row} + {1'b0, base};
		if (row_sum >= ROWS_V) begin
			row_wrap = row_sum - ROWS_V;
		end else begin
			row_wrap = row_sum;
		end
		row_phys  = use_offset ? row_wrap[tcw_pkg::ROW_W-1:0] : row;
		addr_full = tcw_pkg::ADDR_FULL_W'(row_phys) * tcw_pkg::ADDR_FULL_W'(COLUMNS)
			+ tcw_pkg::ADDR_FULL_W'(col);
		addr      = addr_full[ADDR_W-1:0];
	end

endmodule

// ----- sv/tcw_ram.sv -----
// ----------------------------------------------------------------------------
// tcw_ram: screen cell memory
// Single port, one write or one registered read per cycle.
// ----------------------------------------------------------------------------
module tcw_ram #(
	parameter int DEPTH  = 4800,
	parameter int ADDR_W = 13
) (
	input  logic                       clk,
	input  tcw_pkg::ram_ctl_t          ctl,
	input  logic [ADDR_W-1:0]          addr,
	output logic [tcw_pkg::CHAR_W-1:0] rdata
);

	logic [tcw_pkg::CHAR_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[addr] <= ctl.wdata;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (ctl.re) begin
			rdata <= mem[addr];
		end
	end

endmodule

// ----- sv/text_console_writer.sv -----
// ----------------------------------------------------------------------------
// text_console_writer: text-mode screen grid with cursor, put and read requests
// Accept leads to ST_FIN, which loads the output register; one request is taken at a time.
// A scroll passes through ST_CLEAR to clear the bottom row through the RAM port.
// Reset: cursor and scroll base clear at once, then ST_INIT repeats a RAM write cycle
// ----------------------------------------------------------------------------
// clearing cells row-major until the grid is zeroed, while in_stall is held high.
module text_console_writer #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 60
) (
	input  logic                       clk,
	input  logic                       arst_n,

	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       operation,
	input  logic [tcw_pkg::CHAR_W-1:0] char_code,
	input  logic [tcw_pkg::ROW_W-1:0]  read_row,
	input  logic [tcw_pkg::COL_W-1:0]  read_col,

	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [tcw_pkg::CHAR_W-1:0] cell_value,
	output logic [tcw_pkg::COL_W-1:0]  cursor_column,
	output logic [tcw_pkg::ROW_W-1:0]  cursor_line,
	output logic                       did_scroll
);

	localparam int DEPTH  = ROWS * COLUMNS;
	localparam int ADDR_W = $clog2(DEPTH);

	// comparison constants; COLS_V and ROWS_V are one bit wider than the field so the limit fits
	localparam logic [tcw_pkg::COL_W:0]   COLS_V     = (tcw_pkg::COL_W + 1)'(COLUMNS);
	localparam logic [tcw_pkg::ROW_W:0]   ROWS_V     = (tcw_pkg::ROW_W + 1)'(ROWS);
	localparam logic [tcw_pkg::COL_W-1:0] COL_LAST   = tcw_pkg::COL_W'(COLUMNS - 1);
	localparam logic [tcw_pkg::ROW_W-1:0] ROW_LAST   = tcw_pkg::ROW_W'(ROWS - 1);

	// ------------------------------------------------------------------
	// State
	//   col_q/row_q : logical cursor
	//   base_q      : physical RAM row that shows as logical row 0.
	//                 A scroll clears the old top row (which becomes the new
	//                 bottom row) and bumps the base, so no row copy is needed.
	//   clr_*_q     : sweep counters for the reset pass and scroll clears
	// ------------------------------------------------------------------
	tcw_pkg::state_t            state_q, state_nxt;
	logic [tcw_pkg::COL_W-1:0]  col_q;
	logic [tcw_pkg::ROW_W-1:0]  row_q;
	logic [tcw_pkg::ROW_W-1:0]  base_q;
	logic [tcw_pkg::COL_W-1:0]  clr_col_q;
	logic [tcw_pkg::ROW_W-1:0]  clr_row_q;
	logic                       res_rd_q;
	logic                       res_scroll_q;

	logic                       out_valid_q;
	logic [tcw_pkg::CHAR_W-1:0] cell_value_q;
	logic [tcw_pkg::COL_W-1:0]  cursor_column_q;
	logic [tcw_pkg::ROW_W-1:0]  cursor_line_q;
	logic                       did_scroll_q;

	// ------------------------------------------------------------------
	// Request decode (only meaningful while idle)
	// ------------------------------------------------------------------
	logic                      accept;
	logic                      is_put, is_cr, is_lf, is_bs, is_char;
	logic [tcw_pkg::COL_W:0]   col_inc;
	logic                      col_wrap;
	logic                      line_adv;
	logic                      on_last_row;
	logic                      scroll_now;
	logic                      rd_ok;
	logic                      clr_col_end;
	logic                      out_load;

	always_comb begin
		accept      = in_valid && (state_q == tcw_pkg::ST_IDLE);
		is_put      = (operation == tcw_pkg::OP_PUT);
		is_cr       = is_put && (char_code == tcw_pkg::CODE_RETURN);
		is_lf       = is_put && (char_code == tcw_pkg::CODE_LINEFEED);
		is_bs       = is_put && (char_code == tcw_pkg::CODE_BACKSPACE);
		is_char     = is_put && !is_cr && !is_lf && !is_bs;
		col_inc     = {1'b0, col_q} + 1'b1;
		col_wrap    = (col_inc >= COLS_V);
		line_adv    = is_lf || (is_char && col_wrap);
		on_last_row = (row_q >= ROW_LAST);
		scroll_now  = line_adv && on_last_row;
		rd_ok       = !is_put && ({1'b0, read_row} < ROWS_V) && ({1'b0, read_col} < COLS_V);
		clr_col_end = (clr_col_q == COL_LAST);
		out_load    = (state_q == tcw_pkg::ST_FIN) && (!out_valid_q || !out_stall);
	end

	// ------------------------------------------------------------------
	// Sequencer: next state
	// ------------------------------------------------------------------
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			tcw_pkg::ST_INIT: begin
				if (clr_col_end && (clr_row_q == ROW_LAST)) begin
					state_nxt = tcw_pkg::ST_IDLE;
				end
			end
			tcw_pkg::ST_IDLE: begin
				if (accept) begin
					state_nxt = scroll_now ? tcw_pkg::ST_CLEAR : tcw_pkg::ST_FIN;
				end
			end
			tcw_pkg::ST_CLEAR: begin
				if (clr_col_end) begin
					state_nxt = tcw_pkg::ST_FIN;
				end
			end
			tcw_pkg::ST_FIN: begin
				if (out_load) begin
					state_nxt = tcw_pkg::ST_IDLE;
				end
			end
			default: state_nxt = tcw_pkg::ST_INIT;
		endcase
	end

	// ------------------------------------------------------------------
	// Sequencer: outputs to the address unit and the RAM
	// Idle uses the cursor (put) or the request coordinates (read), mapped
	// through the scroll base. The sweeps address physical rows directly.
	// ------------------------------------------------------------------
	tcw_pkg::ram_ctl_t          ram_ctl;
	logic                       addr_use_offset;
	logic [tcw_pkg::ROW_W-1:0]  addr_row;
	logic [tcw_pkg::COL_W-1:0]  addr_col;
	logic [ADDR_W-1:0]          ram_addr;
	logic [tcw_pkg::CHAR_W-1:0] ram_rdata;

	always_comb begin
		ram_ctl         = '0;
		addr_use_offset = 1'b0;
		addr_row        = clr_row_q;
		addr_col        = clr_col_q;
		unique case (state_q)
			tcw_pkg::ST_INIT, tcw_pkg::ST_CLEAR: begin
				ram_ctl.we = 1'b1;
			end
			tcw_pkg::ST_IDLE: begin
				addr_use_offset = 1'b1;
				addr_row        = is_put ? row_q : read_row;
				addr_col        = is_put ? col_q : read_col;
				ram_ctl.we      = accept && is_char;
				ram_ctl.re      = accept && rd_ok;
				ram_ctl.wdata   = char_code;
			end
			tcw_pkg::ST_FIN: begin
			end
			default: begin
			end
		endcase
	end

	tcw_addr #(
		.ROWS    (ROWS),
		.COLUMNS (COLUMNS),
		.ADDR_W  (ADDR_W)
	) u_addr (
		.use_offset (addr_use_offset),
		.row        (addr_row),
		.col        (addr_col),
		.base       (base_q),
		.addr       (ram_addr)
	);

	tcw_ram #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk   (clk),
		.ctl   (ram_ctl),
		.addr  (ram_addr),
		.rdata (ram_rdata)
	);

	// ------------------------------------------------------------------
	// Registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= tcw_pkg::ST_INIT;
			col_q        <= '0;
			row_q        <= '0;
			base_q       <= '0;
			clr_col_q    <= '0;
			clr_row_q    <= '0;
			res_rd_q     <= 1'b0;
			res_scroll_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			unique case (state_q)
				tcw_pkg::ST_INIT: begin
					// row-major sweep of every physical row
					if (clr_col_end) begin
						clr_col_q <= '0;
						clr_row_q <= clr_row_q + 1'b1;
					end else begin
						clr_col_q <= clr_col_q + 1'b1;
					end
				end
				tcw_pkg::ST_IDLE: begin
					if (accept) begin
						res_rd_q     <= rd_ok;
						res_scroll_q <= scroll_now;
						// the row to clear on a scroll is the current top row
						clr_row_q    <= base_q;
						clr_col_q    <= '0;
						if (is_cr) begin
							col_q <= '0;
						end else if (is_bs) begin
							if (col_q != '0) begin
								col_q <= col_q - 1'b1;
							end
						end else if (is_char) begin
							col_q <= col_wrap ? '0 : col_inc[tcw_pkg::COL_W-1:0];
						end
						// cursor stays on the last row when the screen scrolls
						if (line_adv && !on_last_row) begin
							row_q <= row_q + 1'b1;
						end
					end
				end
				tcw_pkg::ST_CLEAR: begin
					clr_col_q <= clr_col_q + 1'b1;
					if (clr_col_end) begin
						base_q <= (base_q == ROW_LAST) ? '0 : base_q + 1'b1;
					end
				end
				tcw_pkg::ST_FIN: begin
				end
				default: begin
				end
			endcase
		end
	end

	// Output register: parts the result from the sequencer so a waiting
	// result does not hold the RAM busy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			cell_value_q    <= res_rd_q ? ram_rdata : '0;
			cursor_column_q <= col_q;
			cursor_line_q   <= row_q;
			did_scroll_q    <= res_scroll_q;
		end
	end

	assign in_stall      = (state_q != tcw_pkg::ST_IDLE);
	assign out_valid     = out_valid_q;
	assign cell_value    = cell_value_q;
	assign cursor_column = cursor_column_q;
	assign cursor_line   = cursor_line_q;
	assign did_scroll    = did_scroll_q;

endmodule
